// File: rtl/core/ypcm_pkg.sv
// Shared types, register indexes, command codes and constants of the yaw/pitch camera block.
package ypcm_pkg;

   typedef struct packed {
      logic               action;
      logic signed [15:0] look_dx;
      logic signed [15:0] look_dy;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [15:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_type;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_SPEED  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_LIMIT = 1'd1;
   localparam logic [15:0] MOVE_SPEED_RESET  = 16'd256;
   localparam logic [13:0] PITCH_LIMIT_RESET = 14'd16056;

   // vector formats
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   // CORDIC
   localparam int CORDIC_W     = 18;
   localparam int CORDIC_STEPS = 14;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 18'sd9949;

   // normalization unit
   localparam int LEN2_W     = 60;
   localparam int SQRT_STEPS = LEN2_W / 2;
   localparam int LEN_W      = LEN2_W / 2;
   localparam int Q_W        = 15;
   localparam int NUM_W      = 47;
   localparam int RAW_W      = 32;

   // datapath commands
   localparam logic [3:0] OP_NOP       = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_ANGLE     = 4'd2;
   localparam logic [3:0] OP_CORDIC_GO = 4'd3;
   localparam logic [3:0] OP_FRONT_MUL = 4'd4;
   localparam logic [3:0] OP_RIGHT_RAW = 4'd5;
   localparam logic [3:0] OP_UP_MUL    = 4'd6;
   localparam logic [3:0] OP_NORM_GO   = 4'd7;
   localparam logic [3:0] OP_STORE     = 4'd8;
   localparam logic [3:0] OP_SDT       = 4'd9;
   localparam logic [3:0] OP_TERM_AV   = 4'd10;
   localparam logic [3:0] OP_TERM_PP   = 4'd11;
   localparam logic [3:0] OP_TERM_ACC  = 4'd12;
   localparam logic [3:0] OP_POS       = 4'd13;
   localparam logic [3:0] OP_RESP      = 4'd14;

   // basis vector select for OP_STORE
   localparam logic [2:0] SEL_FRONT = 3'd0;
   localparam logic [2:0] SEL_RIGHT = 3'd1;
   localparam logic [2:0] SEL_UP    = 3'd2;

   localparam logic [2:0] LAST_TERM = 3'd6;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] idx;
   } cmd_type;

   typedef struct packed {
      logic is_move;
      logic cordic_done;
      logic norm_done;
   } sts_type;

   function automatic logic signed [CORDIC_W-1:0] atan_step(input logic [3:0] i);
      logic signed [CORDIC_W-1:0] r;
      case (i)
         4'd0:    r = 18'sd8192;
         4'd1:    r = 18'sd4836;
         4'd2:    r = 18'sd2555;
         4'd3:    r = 18'sd1297;
         4'd4:    r = 18'sd651;
         4'd5:    r = 18'sd326;
         4'd6:    r = 18'sd163;
         4'd7:    r = 18'sd81;
         4'd8:    r = 18'sd41;
         4'd9:    r = 18'sd20;
         4'd10:   r = 18'sd10;
         4'd11:   r = 18'sd5;
         4'd12:   r = 18'sd3;
         4'd13:   r = 18'sd1;
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/yaw_pitch_camera_basis_and_motion_top.sv
// Top level of the yaw/pitch camera block: basis update on look events, position on move events.
// A move event runs seven multiply terms, each through the AV, PP and ACC states; a look event
// runs the CORDIC, then three normalizations (start, 3 squares, 30 square-root steps,
// 15 divide steps, done, store).
// One item at a time; the next word is taken while the previous result waits in the output register.
// Reset is synchronous and active high; it restores the basis, position and both registers.
module yaw_pitch_camera_basis_and_motion_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ypcm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ypcm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [ypcm_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [ypcm_pkg::CSR_DATA_W-1:0]    csr_data
);

   ypcm_pkg::cmd_type cmd;
   ypcm_pkg::sts_type sts;

   ypcm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .sts(sts)
   );

   ypcm_dp u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .sts(sts),
      .req_data(req_data), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_data(csr_data)
   );

endmodule

// File: rtl/core/ypcm_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of a binary angle, one step per cycle.
module ypcm_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [15:0]                         angle,
   output logic                                done,
   output logic signed [ypcm_pkg::CORDIC_W-1:0] cos_out,
   output logic signed [ypcm_pkg::CORDIC_W-1:0] sin_out
);

   logic signed [ypcm_pkg::CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, a_ff, a_in;
   logic signed [ypcm_pkg::CORDIC_W-1:0] xs, ys, a0;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [3:0] cnt_ff, cnt_in;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign a0 = {{(ypcm_pkg::CORDIC_W-16){angle[15]}}, angle};

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      a_in = a_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = ypcm_pkg::CORDIC_START;
         y_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
         // fold into a half turn around zero; a half-turn fold flips both signs
         if (a0 > 18'sd16384) begin
            a_in = a0 - 18'sd32768;
            neg_in = 1'b1;
         end else if (a0 < -18'sd16384) begin
            a_in = a0 + 18'sd32768;
            neg_in = 1'b1;
         end else begin
            a_in = a0;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!a_ff[ypcm_pkg::CORDIC_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            a_in = a_ff - ypcm_pkg::atan_step(cnt_ff);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            a_in = a_ff + ypcm_pkg::atan_step(cnt_ff);
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(ypcm_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      a_ff <= a_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

// File: rtl/core/ypcm_norm.sv
// Vector normalization unit: sum of squares, bitwise square root, three restoring dividers.
module ypcm_norm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ypcm_pkg::RAW_W-1:0]     vin [3],
   output logic                                  done,
   output logic signed [15:0]                    vout [3]
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SQ   = 2'd1;
   localparam logic [1:0] PH_SQRT = 2'd2;
   localparam logic [1:0] PH_DIV  = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [4:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [31:0] mag_ff [3];
   logic [31:0] mag_in [3];
   logic [2:0] neg_ff, neg_in;
   logic [ypcm_pkg::LEN2_W-1:0] acc_ff, acc_in, rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [ypcm_pkg::LEN2_W-1:0] sq, trial, res_next;
   logic [63:0] prod;
   logic zero_ff, zero_in;
   logic [ypcm_pkg::NUM_W-1:0] dsh_ff, dsh_in;
   logic [ypcm_pkg::NUM_W-1:0] num_ff [3];
   logic [ypcm_pkg::NUM_W-1:0] num_in [3];
   logic [ypcm_pkg::Q_W-1:0] q_ff [3];
   logic [ypcm_pkg::Q_W-1:0] q_in [3];
   logic [ypcm_pkg::LEN_W-1:0] len;

   assign prod = mag_ff[cnt_ff[1:0]] * mag_ff[cnt_ff[1:0]];
   assign sq = prod[ypcm_pkg::LEN2_W-1:0];
   assign trial = res_ff + bit_ff;
   assign res_next = (rem_ff >= trial) ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
   assign len = res_next[ypcm_pkg::LEN_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      mag_in = mag_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      zero_in = zero_ff;
      dsh_in = dsh_ff;
      num_in = num_ff;
      q_in = q_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               for (int k = 0; k < 3; k++) begin
                  neg_in[k] = vin[k][ypcm_pkg::RAW_W-1];
                  mag_in[k] = vin[k][ypcm_pkg::RAW_W-1] ? 32'(-vin[k]) : 32'(vin[k]);
               end
               acc_in = '0;
               cnt_in = '0;
               phase_in = PH_SQ;
            end
         end
         PH_SQ: begin
            acc_in = acc_ff + sq;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd2) begin
               rem_in = acc_ff + sq;
               res_in = '0;
               bit_in = {2'b01, {(ypcm_pkg::LEN2_W-2){1'b0}}};
               cnt_in = '0;
               phase_in = PH_SQRT;
            end
         end
         PH_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
            end
            res_in = res_next;
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ypcm_pkg::SQRT_STEPS - 1)) begin
               zero_in = (len == '0);
               dsh_in = ypcm_pkg::NUM_W'({len, 14'b0});
               for (int k = 0; k < 3; k++) begin
                  num_in[k] = ypcm_pkg::NUM_W'({mag_ff[k], 14'b0})
                            + ypcm_pkg::NUM_W'(len >> 1);
                  q_in[k] = '0;
               end
               cnt_in = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            for (int k = 0; k < 3; k++) begin
               if (num_ff[k] >= dsh_ff) begin
                  num_in[k] = num_ff[k] - dsh_ff;
                  q_in[k] = {q_ff[k][ypcm_pkg::Q_W-2:0], 1'b1};
               end else begin
                  q_in[k] = {q_ff[k][ypcm_pkg::Q_W-2:0], 1'b0};
               end
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ypcm_pkg::Q_W - 1)) begin
               done_in = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      zero_ff <= zero_in;
      dsh_ff <= dsh_in;
      num_ff <= num_in;
      q_ff <= q_in;
   end

   assign done = done_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (zero_ff) vout[k] = '0;
         else if (neg_ff[k]) vout[k] = -$signed({1'b0, q_ff[k]});
         else vout[k] = $signed({1'b0, q_ff[k]});
      end
   end

endmodule

// File: rtl/core/ypcm_dp.sv
// Datapath: camera state, angle update, basis products, move terms and the result register.
module ypcm_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  ypcm_pkg::cmd_type                  cmd,
   output ypcm_pkg::sts_type                  sts,
   input  ypcm_pkg::req_type                  req_data,
   output ypcm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [ypcm_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [ypcm_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam logic signed [34:0] POS_MAX = 35'sd2147483647;
   localparam logic signed [34:0] POS_MIN = -35'sd2147483648;

   ypcm_pkg::req_type req_ff;
   ypcm_pkg::rsp_type rsp_ff;
   logic [15:0] speed_ff;
   logic [13:0] limit_ff;
   logic [15:0] yaw_ff;
   logic signed [15:0] pitch_ff;
   logic signed [15:0] front_ff [3];
   logic signed [15:0] right_ff [3];
   logic signed [15:0] up_ff [3];
   logic signed [31:0] pos_ff [3];
   logic signed [ypcm_pkg::RAW_W-1:0] raw_ff [3];
   logic [31:0] sdt_ff;
   logic signed [32:0] av_ff;
   logic signed [49:0] lo_ff, hi_ff;
   logic signed [33:0] d_ff [3];

   logic signed [ypcm_pkg::CORDIC_W-1:0] cy, sy, cp, sp;
   logic cy_done, cp_done, norm_done, cordic_go, norm_go;
   logic signed [15:0] nout [3];

   logic signed [17:0] p_new, lim;
   logic signed [35:0] m0, m2;
   logic signed [15:0] ua, ub, uc, ud;
   logic signed [32:0] uraw;
   logic signed [16:0] ta;
   logic signed [15:0] tv;
   logic signed [66:0] full;
   logic signed [66:0] term;
   logic [1:0] tk;

   assign cordic_go = (cmd.op == ypcm_pkg::OP_CORDIC_GO);
   assign norm_go = (cmd.op == ypcm_pkg::OP_NORM_GO);

   ypcm_cordic u_cordic_yaw (
      .clock(clock), .reset(reset), .start(cordic_go), .angle(yaw_ff),
      .done(cy_done), .cos_out(cy), .sin_out(sy)
   );

   ypcm_cordic u_cordic_pitch (
      .clock(clock), .reset(reset), .start(cordic_go), .angle(pitch_ff),
      .done(cp_done), .cos_out(cp), .sin_out(sp)
   );

   ypcm_norm u_norm (
      .clock(clock), .reset(reset), .start(norm_go), .vin(raw_ff),
      .done(norm_done), .vout(nout)
   );

   assign sts.is_move = req_ff.action;
   assign sts.cordic_done = cy_done & cp_done;
   assign sts.norm_done = norm_done;

   assign p_new = $signed({{2{pitch_ff[15]}}, pitch_ff})
                - $signed({{2{req_ff.look_dy[15]}}, req_ff.look_dy});
   assign lim = $signed({4'b0, limit_ff});

   assign m0 = cy * cp;
   assign m2 = sy * cp;

   // up = right x front, one component per command
   always_comb begin
      case (cmd.idx)
         3'd0: begin ua = right_ff[1]; ub = front_ff[2]; uc = right_ff[2]; ud = front_ff[1]; end
         3'd1: begin ua = right_ff[2]; ub = front_ff[0]; uc = right_ff[0]; ud = front_ff[2]; end
         default: begin ua = right_ff[0]; ub = front_ff[1]; uc = right_ff[1]; ud = front_ff[0]; end
      endcase
   end
   assign uraw = 33'(ua * ub) - 33'(uc * ud);

   // move terms: speed*dt*a*v, with a taken along dir, right or world up
   always_comb begin
      case (cmd.idx)
         3'd0: begin ta = -$signed({req_ff.accel_z[15], req_ff.accel_z}); tv = req_ff.dir_x; tk = 2'd0; end
         3'd1: begin ta = -$signed({req_ff.accel_z[15], req_ff.accel_z}); tv = req_ff.dir_y; tk = 2'd1; end
         3'd2: begin ta = -$signed({req_ff.accel_z[15], req_ff.accel_z}); tv = req_ff.dir_z; tk = 2'd2; end
         3'd3: begin ta = $signed({req_ff.accel_x[15], req_ff.accel_x}); tv = right_ff[0]; tk = 2'd0; end
         3'd4: begin ta = $signed({req_ff.accel_x[15], req_ff.accel_x}); tv = right_ff[1]; tk = 2'd1; end
         3'd5: begin ta = $signed({req_ff.accel_x[15], req_ff.accel_x}); tv = right_ff[2]; tk = 2'd2; end
         default: begin ta = $signed({req_ff.accel_y[15], req_ff.accel_y}); tv = ypcm_pkg::ONE_Q14; tk = 2'd1; end
      endcase
   end
   assign full = $signed({hi_ff[49], hi_ff, 16'b0}) + $signed({{17{lo_ff[49]}}, lo_ff});
   assign term = full >>> 36;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= ypcm_pkg::MOVE_SPEED_RESET;
         limit_ff <= ypcm_pkg::PITCH_LIMIT_RESET;
         yaw_ff <= '0;
         pitch_ff <= '0;
         front_ff[0] <= ypcm_pkg::ONE_Q14; front_ff[1] <= '0; front_ff[2] <= '0;
         right_ff[0] <= '0; right_ff[1] <= '0; right_ff[2] <= ypcm_pkg::ONE_Q14;
         up_ff[0] <= '0; up_ff[1] <= ypcm_pkg::ONE_Q14; up_ff[2] <= '0;
         for (int k = 0; k < 3; k++) pos_ff[k] <= '0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               ypcm_pkg::CSR_MOVE_SPEED:  speed_ff <= csr_data;
               ypcm_pkg::CSR_PITCH_LIMIT: limit_ff <= csr_data[13:0];
               default: ;
            endcase
         end
         case (cmd.op)
            ypcm_pkg::OP_ANGLE: begin
               yaw_ff <= yaw_ff + req_ff.look_dx;
               if (p_new > lim) pitch_ff <= lim[15:0];
               else if (p_new < -lim) pitch_ff <= 16'(-lim);
               else pitch_ff <= p_new[15:0];
            end
            ypcm_pkg::OP_STORE: begin
               case (cmd.idx)
                  ypcm_pkg::SEL_FRONT: front_ff <= nout;
                  ypcm_pkg::SEL_RIGHT: right_ff <= nout;
                  default: up_ff <= nout;
               endcase
            end
            ypcm_pkg::OP_POS: begin
               for (int k = 0; k < 3; k++) begin
                  if ($signed({{3{pos_ff[k][31]}}, pos_ff[k]}) + $signed({d_ff[k][33], d_ff[k]}) > POS_MAX)
                     pos_ff[k] <= POS_MAX[31:0];
                  else if ($signed({{3{pos_ff[k][31]}}, pos_ff[k]})
                           + $signed({d_ff[k][33], d_ff[k]}) < POS_MIN)
                     pos_ff[k] <= POS_MIN[31:0];
                  else
                     pos_ff[k] <= pos_ff[k] + d_ff[k][31:0];
               end
            end
            default: ;
         endcase
      end

      // payload and scratch registers
      case (cmd.op)
         ypcm_pkg::OP_LOAD: req_ff <= req_data;
         ypcm_pkg::OP_FRONT_MUL: begin
            raw_ff[0] <= 32'(m0 >>> 14);
            raw_ff[1] <= 32'(sp);
            raw_ff[2] <= 32'(m2 >>> 14);
         end
         ypcm_pkg::OP_RIGHT_RAW: begin
            raw_ff[0] <= 32'(-sy);
            raw_ff[1] <= '0;
            raw_ff[2] <= 32'(cy);
         end
         ypcm_pkg::OP_UP_MUL: raw_ff[cmd.idx[1:0]] <= 32'(uraw);
         ypcm_pkg::OP_SDT: begin
            sdt_ff <= speed_ff * req_ff.time_step;
            for (int k = 0; k < 3; k++) d_ff[k] <= '0;
         end
         ypcm_pkg::OP_TERM_AV: av_ff <= ta * tv;
         ypcm_pkg::OP_TERM_PP: begin
            lo_ff <= av_ff * $signed({1'b0, sdt_ff[15:0]});
            hi_ff <= av_ff * $signed({1'b0, sdt_ff[31:16]});
         end
         ypcm_pkg::OP_TERM_ACC: d_ff[tk] <= d_ff[tk] + 34'(term);
         ypcm_pkg::OP_RESP: begin
            rsp_ff.front_x <= front_ff[0];
            rsp_ff.front_y <= front_ff[1];
            rsp_ff.front_z <= front_ff[2];
            rsp_ff.right_x <= right_ff[0];
            rsp_ff.right_y <= right_ff[1];
            rsp_ff.right_z <= right_ff[2];
            rsp_ff.up_x <= up_ff[0];
            rsp_ff.up_y <= up_ff[1];
            rsp_ff.up_z <= up_ff[2];
            rsp_ff.pos_x <= pos_ff[0];
            rsp_ff.pos_y <= pos_ff[1];
            rsp_ff.pos_z <= pos_ff[2];
         end
         default: ;
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/core/ypcm_ctrl.sv
// Controller: sequences look and move events over the datapath and runs both handshakes.
module ypcm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ypcm_pkg::cmd_type cmd,
   input  ypcm_pkg::sts_type sts
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DECODE    = 4'd1;
   localparam logic [3:0] ST_ANGLE     = 4'd2;
   localparam logic [3:0] ST_CORDIC_GO = 4'd3;
   localparam logic [3:0] ST_CORDIC_WT = 4'd4;
   localparam logic [3:0] ST_FRONT_MUL = 4'd5;
   localparam logic [3:0] ST_NORM_GO   = 4'd6;
   localparam logic [3:0] ST_NORM_WT   = 4'd7;
   localparam logic [3:0] ST_STORE     = 4'd8;
   localparam logic [3:0] ST_RIGHT_RAW = 4'd9;
   localparam logic [3:0] ST_UP_MUL    = 4'd10;
   localparam logic [3:0] ST_SDT       = 4'd11;
   localparam logic [3:0] ST_TERM_AV   = 4'd12;
   localparam logic [3:0] ST_TERM_PP   = 4'd13;
   localparam logic [3:0] ST_TERM_ACC  = 4'd14;
   localparam logic [3:0] ST_POS       = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [2:0] sel_ff, sel_in, cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in, resp_wait_ff, resp_wait_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || resp_wait_ff;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cnt_in = cnt_ff;
      resp_wait_in = resp_wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op = ypcm_pkg::OP_NOP;
      cmd.idx = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            // a finished word waits here for the output register to free up
            if (resp_wait_ff) begin
               if (out_free) begin
                  cmd.op = ypcm_pkg::OP_RESP;
                  rsp_valid_in = 1'b1;
                  resp_wait_in = 1'b0;
               end
            end else if (req_valid) begin
               cmd.op = ypcm_pkg::OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: state_in = sts.is_move ? ST_SDT : ST_ANGLE;
         ST_ANGLE: begin
            cmd.op = ypcm_pkg::OP_ANGLE;
            state_in = ST_CORDIC_GO;
         end
         ST_CORDIC_GO: begin
            cmd.op = ypcm_pkg::OP_CORDIC_GO;
            state_in = ST_CORDIC_WT;
         end
         ST_CORDIC_WT: if (sts.cordic_done) state_in = ST_FRONT_MUL;
         ST_FRONT_MUL: begin
            cmd.op = ypcm_pkg::OP_FRONT_MUL;
            sel_in = ypcm_pkg::SEL_FRONT;
            state_in = ST_NORM_GO;
         end
         ST_NORM_GO: begin
            cmd.op = ypcm_pkg::OP_NORM_GO;
            state_in = ST_NORM_WT;
         end
         ST_NORM_WT: if (sts.norm_done) state_in = ST_STORE;
         ST_STORE: begin
            cmd.op = ypcm_pkg::OP_STORE;
            cmd.idx = sel_ff;
            case (sel_ff)
               ypcm_pkg::SEL_FRONT: state_in = ST_RIGHT_RAW;
               ypcm_pkg::SEL_RIGHT: begin
                  cnt_in = '0;
                  state_in = ST_UP_MUL;
               end
               default: begin
                  resp_wait_in = 1'b1;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_RIGHT_RAW: begin
            cmd.op = ypcm_pkg::OP_RIGHT_RAW;
            sel_in = ypcm_pkg::SEL_RIGHT;
            state_in = ST_NORM_GO;
         end
         ST_UP_MUL: begin
            cmd.op = ypcm_pkg::OP_UP_MUL;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd2) begin
               sel_in = ypcm_pkg::SEL_UP;
               state_in = ST_NORM_GO;
            end
         end
         ST_SDT: begin
            cmd.op = ypcm_pkg::OP_SDT;
            cnt_in = '0;
            state_in = ST_TERM_AV;
         end
         ST_TERM_AV: begin
            cmd.op = ypcm_pkg::OP_TERM_AV;
            state_in = ST_TERM_PP;
         end
         ST_TERM_PP: begin
            cmd.op = ypcm_pkg::OP_TERM_PP;
            state_in = ST_TERM_ACC;
         end
         ST_TERM_ACC: begin
            cmd.op = ypcm_pkg::OP_TERM_ACC;
            cnt_in = cnt_ff + 3'd1;
            state_in = (cnt_ff == ypcm_pkg::LAST_TERM) ? ST_POS : ST_TERM_AV;
         end
         ST_POS: begin
            cmd.op = ypcm_pkg::OP_POS;
            resp_wait_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         resp_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         resp_wait_ff <= resp_wait_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: tb/testbench.sv
// Testbench for the yaw/pitch camera block: scoreboard with a bit-exact predictor, random traffic.
`timescale 1ns / 100ps

module testbench;

   localparam logic ACT_LOOK = 1'b0;
   localparam logic ACT_MOVE = 1'b1;
   localparam int REQ_W = $bits(ypcm_pkg::req_type);

   class camera_scoreboard;
      int atan_tab[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      logic [15:0] speed;
      logic [13:0] pitch_lim;
      logic [15:0] yaw;
      int          pitch;
      int          front[3];
      int          right[3];
      int          up[3];
      int          pos[3];
      ypcm_pkg::rsp_type expected_views[$];
      int          errors;

      function new();
         speed = ypcm_pkg::MOVE_SPEED_RESET;
         pitch_lim = ypcm_pkg::PITCH_LIMIT_RESET;
         yaw = 0;
         pitch = 0;
         front = '{16384, 0, 0};
         right = '{0, 0, 16384};
         up = '{0, 16384, 0};
         pos = '{0, 0, 0};
         errors = 0;
      endfunction

      function void set_reg(logic [ypcm_pkg::CSR_IDX_W-1:0] idx,
                            logic [ypcm_pkg::CSR_DATA_W-1:0] val);
         if (idx == ypcm_pkg::CSR_MOVE_SPEED) speed = val;
         else if (idx == ypcm_pkg::CSR_PITCH_LIMIT) pitch_lim = val[13:0];
      endfunction

      function void sin_cos(input logic [15:0] ang, output int c, output int s);
         int a, x, y, xs, ys;
         bit neg;
         a = int'($signed(ang));
         neg = 0;
         x = 9949;
         y = 0;
         // fold into a half turn; folding negates both
         if (a > 16384) begin
            a -= 32768;
            neg = 1;
         end else if (a < -16384) begin
            a += 32768;
            neg = 1;
         end
         for (int i = 0; i < 14; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0) begin
               x -= ys; y += xs; a -= atan_tab[i];
            end else begin
               x += ys; y -= xs; a += atan_tab[i];
            end
         end
         c = neg ? -x : x;
         s = neg ? -y : y;
      endfunction

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
         end
         return res;
      endfunction

      function void normalize(input longint v[3], output int o[3]);
         longint unsigned len2, len, mag, q;
         len2 = 0;
         for (int k = 0; k < 3; k++) len2 += longint'(v[k] * v[k]);
         len = isqrt(len2);
         for (int k = 0; k < 3; k++) begin
            if (len == 0) o[k] = 0;
            else begin
               mag = v[k] < 0 ? -v[k] : v[k];
               q = (mag * 16384 + len / 2) / len;
               o[k] = v[k] < 0 ? -int'(q) : int'(q);
            end
         end
      endfunction

      function void note_request(ypcm_pkg::req_type r);
         int      cy, sy, cp, sp, lim;
         longint  f[3], rv[3], u[3], sdt, s_dir, s_right, s_up, d, p;
         longint  dir[3];
         ypcm_pkg::rsp_type e;
         if (r.action == ACT_LOOK) begin
            lim = int'(pitch_lim);
            yaw = yaw + r.look_dx;
            pitch = pitch - int'(r.look_dy);
            if (pitch > lim) pitch = lim;
            if (pitch < -lim) pitch = -lim;
            sin_cos(yaw, cy, sy);
            sin_cos(pitch[15:0], cp, sp);
            f[0] = (longint'(cy) * cp) >>> 14;
            f[1] = sp;
            f[2] = (longint'(sy) * cp) >>> 14;
            normalize(f, front);
            rv[0] = -longint'(sy);
            rv[1] = 0;
            rv[2] = cy;
            normalize(rv, right);
            u[0] = longint'(right[1]) * front[2] - longint'(right[2]) * front[1];
            u[1] = longint'(right[2]) * front[0] - longint'(right[0]) * front[2];
            u[2] = longint'(right[0]) * front[1] - longint'(right[1]) * front[0];
            normalize(u, up);
         end else begin
            sdt = longint'(speed) * longint'(r.time_step);
            s_dir = -longint'(r.accel_z) * sdt;
            s_right = longint'(r.accel_x) * sdt;
            s_up = longint'(r.accel_y) * sdt;
            dir[0] = r.dir_x;
            dir[1] = r.dir_y;
            dir[2] = r.dir_z;
            for (int k = 0; k < 3; k++) begin
               d = ((s_dir * dir[k]) >>> 36) + ((s_right * right[k]) >>> 36);
               if (k == 1) d += (s_up * 16384) >>> 36;
               p = longint'(pos[k]) + d;
               if (p > 64'sd2147483647) p = 64'sd2147483647;
               if (p < -64'sd2147483648) p = -64'sd2147483648;
               pos[k] = int'(p);
            end
         end
         e.front_x = 16'(front[0]); e.front_y = 16'(front[1]); e.front_z = 16'(front[2]);
         e.right_x = 16'(right[0]); e.right_y = 16'(right[1]); e.right_z = 16'(right[2]);
         e.up_x = 16'(up[0]); e.up_y = 16'(up[1]); e.up_z = 16'(up[2]);
         e.pos_x = pos[0]; e.pos_y = pos[1]; e.pos_z = pos[2];
         expected_views.push_back(e);
      endfunction

      function void cmp(string nm, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t: mismatch %s expected %0d actual %0d", $time, nm, e, a);
         end
      endfunction

      function void check_response(ypcm_pkg::rsp_type a);
         ypcm_pkg::rsp_type e;
         if (expected_views.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none actual %h", $time, a);
            return;
         end
         e = expected_views.pop_front();
         cmp("front_x", e.front_x, a.front_x);
         cmp("front_y", e.front_y, a.front_y);
         cmp("front_z", e.front_z, a.front_z);
         cmp("right_x", e.right_x, a.right_x);
         cmp("right_y", e.right_y, a.right_y);
         cmp("right_z", e.right_z, a.right_z);
         cmp("up_x", e.up_x, a.up_x);
         cmp("up_y", e.up_y, a.up_y);
         cmp("up_z", e.up_z, a.up_z);
         cmp("pos_x", e.pos_x, a.pos_x);
         cmp("pos_y", e.pos_y, a.pos_y);
         cmp("pos_z", e.pos_z, a.pos_z);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   ypcm_pkg::req_type     req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   ypcm_pkg::rsp_type     rsp_data;
   logic                  csr_we;
   logic [ypcm_pkg::CSR_IDX_W-1:0]  csr_idx;
   logic [ypcm_pkg::CSR_DATA_W-1:0] csr_data;

   camera_scoreboard sb = new();
   bit no_idle;
   int long_hold;

   yaw_pitch_camera_basis_and_motion_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // older word is checked before the new request is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (csr_we) sb.set_reg(csr_idx, csr_data);
      end
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver: random stall before each word, one long hold on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 15);
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
         end
         if (n > 0) begin
            repeat (n) @(negedge clock) rsp_stall <= 1'b1;
            @(negedge clock) rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send(ypcm_pkg::req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.expected_views.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_csr(logic [ypcm_pkg::CSR_IDX_W-1:0] idx,
                            logic [ypcm_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_data <= val;
      @(negedge clock) csr_we <= 1'b0;
   endtask

   function automatic ypcm_pkg::req_type look(logic [15:0] dx, logic [15:0] dy);
      ypcm_pkg::req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r.action = ACT_LOOK;
      r.look_dx = dx;
      r.look_dy = dy;
      return r;
   endfunction

   function automatic ypcm_pkg::req_type move(logic [15:0] ax, logic [15:0] ay,
                                              logic [15:0] az, logic [15:0] dx,
                                              logic [15:0] dy, logic [15:0] dz,
                                              logic [15:0] ts);
      ypcm_pkg::req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r.action = ACT_MOVE;
      r.accel_x = ax; r.accel_y = ay; r.accel_z = az;
      r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
      r.time_step = ts;
      return r;
   endfunction

   function automatic logic [15:0] rnd_q14();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   // drift pushes the position toward one rail to reach saturation
   function automatic ypcm_pkg::req_type rand_item(int drift);
      logic [15:0] dy, big;
      if (drift != 0 && $urandom_range(0, 3) != 0) begin
         big = drift > 0 ? 16'h8000 : 16'h7fff;
         return move(big, big, drift > 0 ? 16'h8000 : 16'h7fff,
                     16'h8000, 16'h8000, 16'h8000, 16'($urandom_range(40000, 65535)));
      end
      if ($urandom_range(0, 1) == 0) begin
         dy = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 4000)) - 2000);
         return look(16'($urandom), dy);
      end
      return move(rnd_q14(), rnd_q14(), rnd_q14(), rnd_q14(), rnd_q14(), rnd_q14(),
                  16'($urandom));
   endfunction

   initial begin
      int speeds[8] = '{0, 65535, 65535, 1, 0, 300, 65535, 0};
      int limits[8] = '{0, 16383, 16383, 1, 0, 8000, 0, 65535};
      int drift;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_data = '0;
      no_idle = 0;
      long_hold = 0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset defaults: yaw on and across the fold points, pitch clamps
      send(look(16'd0, 16'd0));
      send(look(16'd16384, 16'd0));
      send(look(16'd1, 16'd0));
      send(look(16'h8000, 16'd0));
      send(look(16'h7fff, 16'h7fff));
      send(look(16'd0, 16'h8000));
      send(move(16'd16384, 16'd16384, -16'sd16384, 16'd16384, -16'sd16384, 16'd16384,
                16'hffff));
      send(move(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'hffff));
      send(move(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0));
      settle();
      write_csr(ypcm_pkg::CSR_MOVE_SPEED, 16'hffff);
      write_csr(ypcm_pkg::CSR_PITCH_LIMIT, 16'h3fff);
      send(move(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff));
      send(look(16'd100, 16'h8000));
      send(look(16'd0, 16'h7fff));
      settle();
      // a smaller limit only applies at the next look event
      write_csr(ypcm_pkg::CSR_PITCH_LIMIT, 16'd0);
      send(move(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000));
      send(look(16'd0, 16'd0));
      send(look(16'd5000, 16'h8000));
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         write_csr(ypcm_pkg::CSR_MOVE_SPEED, ph == 7 ? 16'($urandom) : 16'(speeds[ph]));
         write_csr(ypcm_pkg::CSR_PITCH_LIMIT, ph >= 4 ? 16'($urandom) : 16'(limits[ph]));
         no_idle = (ph == 2);
         if (ph == 1) long_hold = 700;
         drift = ph == 2 ? 1 : (ph == 6 ? -1 : 0);
         for (int i = 0; i < 175; i++) begin
            if (ph == 6 && i == 120) drift = 1;
            send(rand_item(drift));
         end
         settle();
      end
      no_idle = 0;
      if (sb.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/ypcm_pkg.sv
rtl/core/ypcm_cordic.sv
rtl/core/ypcm_norm.sv
rtl/core/ypcm_dp.sv
rtl/core/ypcm_ctrl.sv
rtl/core/yaw_pitch_camera_basis_and_motion_top.sv
tb/testbench.sv
